// File: rtl/core/nested_tlv_stream_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Nested TLV stream parser assertion macros
// Shared concurrent assertion forms for the checker of the parser unit.
// ----------------------------------------------------------------------------
`ifndef NESTED_TLV_STREAM_PARSER_UNIT_DEFINES_SVH
`define NESTED_TLV_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define NTLV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define NTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ntlv_pkg.sv
// ----------------------------------------------------------------------------
// ntlv_pkg
// Types and constants shared by the nested TLV stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ntlv_pkg;

    localparam int LEVEL_BITS_DEF  = 8;
    localparam int LENGTH_BITS_DEF = 64;
    localparam int LEN_LANES       = 8;

    localparam logic [7:0] LIMIT_RESET   = 8'd15;
    localparam logic [3:0] NIBBLE_MARK   = 4'hF;
    localparam logic [2:0] END_CODE      = 3'h7;
    localparam logic [3:0] MAX_LEN_WIDTH = 4'd8;
    localparam logic [3:0] POS_MAX       = 4'd15;
    localparam int         EXT_FLAG_BIT  = 7;

    typedef enum logic [3:0] {
        KIND_HEADER  = 4'd0,
        KIND_END     = 4'd1,
        KIND_SKIP    = 4'd2,
        KIND_IDLEN   = 4'd3,
        KIND_ID      = 4'd4,
        KIND_EXTHDR  = 4'd5,
        KIND_EXTLEN  = 4'd6,
        KIND_EXT     = 4'd7,
        KIND_DATALEN = 4'd8,
        KIND_DATA    = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_WIDE_LEN  = 2'd2
    } err_t;

    typedef struct packed {
        kind_t      byte_kind;
        logic [7:0] payload;
        logic [7:0] level;
        logic [7:0] ext_tag;
        logic       field_last;
        logic       element_start;
        logic       element_end;
        err_t       error;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/ntlv_byte_if.sv
// ----------------------------------------------------------------------------
// ntlv_byte_if
// Valid/ready channel carrying one byte of the encoded stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntlv_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);

endinterface

`default_nettype wire

// File: rtl/core/ntlv_result_if.sv
// ----------------------------------------------------------------------------
// ntlv_result_if
// Valid/ready channel carrying the classification of one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntlv_result_if;

    logic       valid;
    logic       ready;
    logic [3:0] byte_kind;
    logic [7:0] payload;
    logic [7:0] level;
    logic [7:0] ext_tag;
    logic       field_last;
    logic       element_start;
    logic       element_end;
    logic [1:0] error;

    modport source (
        output valid, output byte_kind, output payload, output level,
        output ext_tag, output field_last, output element_start,
        output element_end, output error, input ready
    );
    modport sink (
        input valid, input byte_kind, input payload, input level,
        input ext_tag, input field_last, input element_start,
        input element_end, input error, output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/nested_tlv_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// nested_tlv_stream_parser_unit
// Classifies each byte of a nested length-prefixed markup stream.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Carries
//   stream    in    data_byte, one encoded byte per transfer
//   parsed    out   byte kind, payload, level, tag, field and element events
//   cfg       in    ext_mixed_limit write (cfg_wr_en, cfg_wr_data)
//
// A new byte is accepted in every cycle in which the result register is free or being taken.
// The result of a transfer appears on the output in the cycle after the transfer.
// The throughput is set by the single result register, which is refilled
// in the same cycle that its content is taken.
// Reset clears all parser state at once; no clearing pass follows.
// A stall on the output holds the result and stops input only when full.
//
`default_nettype none

module nested_tlv_stream_parser_unit
    import ntlv_pkg::*;
#(
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    ntlv_byte_if.sink       stream,
    ntlv_result_if.source   parsed
);

    logic    step;
    logic    stage_free;
    result_t step_res;
    result_t out_res;

    assign stream.ready = stage_free;
    assign step         = stream.valid && stage_free;

    ntlv_parse_core #(
        .LEVEL_BITS  (LEVEL_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (stream.data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (step_res)
    );

    ntlv_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step),
        .res_in  (step_res),
        .take    (parsed.ready),
        .free    (stage_free),
        .valid   (parsed.valid),
        .res_out (out_res)
    );

    assign parsed.byte_kind     = out_res.byte_kind;
    assign parsed.payload       = out_res.payload;
    assign parsed.level         = out_res.level;
    assign parsed.ext_tag       = out_res.ext_tag;
    assign parsed.field_last    = out_res.field_last;
    assign parsed.element_start = out_res.element_start;
    assign parsed.element_end   = out_res.element_end;
    assign parsed.error         = out_res.error;

endmodule

`default_nettype wire

// File: rtl/core/ntlv_parse_core.sv
// ----------------------------------------------------------------------------
// ntlv_parse_core
// Parser state and the single-step classification of one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ntlv_parse_core
    import ntlv_pkg::*;
#(
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    output result_t         res
);

    localparam int LvlW = (LEVEL_BITS > 8) ? LEVEL_BITS : 8;

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_IDLEN   = 8'b0000_0010,
        PH_ID      = 8'b0000_0100,
        PH_EXTHDR  = 8'b0000_1000,
        PH_EXTLEN  = 8'b0001_0000,
        PH_EXT     = 8'b0010_0000,
        PH_DATALEN = 8'b0100_0000,
        PH_DATA    = 8'b1000_0000
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]   remaining_reg, remaining_next;
    logic [LENGTH_BITS-1:0]   accum_reg, accum_next;
    logic [3:0]               bytes_left_reg, bytes_left_next;
    logic [3:0]               position_reg, position_next;
    logic [3:0]               data_width_reg, data_width_next;
    logic                     ext_pending_reg, ext_pending_next;
    logic [7:0]               ext_count_reg, ext_count_next;
    logic [3:0]               ext_id_reg, ext_id_next;
    logic [LEVEL_BITS-1:0]    nest_reg, nest_next;
    logic [7:0]               limit_reg;

    logic [8*LEN_LANES-1:0]   lane_wide;
    logic [LvlW-1:0]          lvl_cur, lvl_new;
    logic [7:0]               cur_tag;
    logic                     go_after_id, go_after_ext, go_after_exts, go_complete;

    assign lvl_cur = LvlW'(nest_reg);
    assign lvl_new = LvlW'(nest_next);
    assign cur_tag = (ext_count_reg > limit_reg) ? ext_count_reg : {4'b0, ext_id_reg};

    always_comb
    begin
        for (int i = 0; i < LEN_LANES; i++)
        begin
            lane_wide[i*8 +: 8] = (position_reg[2:0] == 3'(i)) ? data_byte : 8'd0;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        accum_next       = accum_reg;
        bytes_left_next  = bytes_left_reg;
        position_next    = position_reg;
        data_width_next  = data_width_reg;
        ext_pending_next = ext_pending_reg;
        ext_count_next   = ext_count_reg;
        ext_id_next      = ext_id_reg;
        nest_next        = nest_reg;
        go_after_id      = 1'b0;
        go_after_ext     = 1'b0;
        go_after_exts    = 1'b0;
        go_complete      = 1'b0;

        res               = '0;
        res.byte_kind     = KIND_HEADER;
        res.error         = ERR_NONE;
        res.payload       = data_byte;
        res.level         = lvl_cur[7:0];

        case (phase_reg)
            PH_IDLEN, PH_EXTLEN, PH_DATALEN:
            begin
                if (phase_reg == PH_IDLEN)
                begin
                    res.byte_kind = KIND_IDLEN;
                end
                else if (phase_reg == PH_EXTLEN)
                begin
                    res.byte_kind = KIND_EXTLEN;
                    res.ext_tag   = cur_tag;
                end
                else
                begin
                    res.byte_kind = KIND_DATALEN;
                end
                if (!position_reg[3])
                begin
                    accum_next = accum_reg | lane_wide[LENGTH_BITS-1:0];
                end
                if (position_reg != POS_MAX)
                begin
                    position_next = position_reg + 4'd1;
                end
                if (bytes_left_reg != 4'd0)
                begin
                    bytes_left_next = bytes_left_reg - 4'd1;
                end
                if (bytes_left_reg <= 4'd1)
                begin
                    res.field_last = 1'b1;
                    remaining_next = accum_next;
                    if (accum_next != '0)
                    begin
                        if (phase_reg == PH_IDLEN)
                        begin
                            phase_next = PH_ID;
                        end
                        else if (phase_reg == PH_EXTLEN)
                        begin
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else if (phase_reg == PH_IDLEN)
                    begin
                        go_after_id = 1'b1;
                    end
                    else if (phase_reg == PH_EXTLEN)
                    begin
                        go_after_ext = 1'b1;
                    end
                    else
                    begin
                        go_complete = 1'b1;
                    end
                end
            end
            PH_ID, PH_EXT, PH_DATA:
            begin
                if (phase_reg == PH_ID)
                begin
                    res.byte_kind = KIND_ID;
                end
                else if (phase_reg == PH_EXT)
                begin
                    res.byte_kind = KIND_EXT;
                    res.ext_tag   = cur_tag;
                end
                else
                begin
                    res.byte_kind = KIND_DATA;
                end
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                end
                if (remaining_reg <= LENGTH_BITS'(1))
                begin
                    res.field_last = 1'b1;
                    if (phase_reg == PH_ID)
                    begin
                        go_after_id = 1'b1;
                    end
                    else if (phase_reg == PH_EXT)
                    begin
                        go_after_ext = 1'b1;
                    end
                    else
                    begin
                        go_complete = 1'b1;
                    end
                end
            end
            PH_EXTHDR:
            begin
                res.byte_kind    = KIND_EXTHDR;
                ext_id_next      = data_byte[3:0];
                ext_pending_next = data_byte[EXT_FLAG_BIT];
                res.ext_tag      = (ext_count_reg > limit_reg) ? ext_count_reg
                                                               : {4'b0, data_byte[3:0]};
                accum_next       = '0;
                position_next    = 4'd0;
                bytes_left_next  = {1'b0, data_byte[6:4]} + 4'd1;
                phase_next       = PH_EXTLEN;
            end
            default:
            begin
                phase_next = PH_HEADER;
                if (data_byte[3:0] == NIBBLE_MARK)
                begin
                    if (data_byte[6:4] == END_CODE)
                    begin
                        res.byte_kind   = KIND_END;
                        res.element_end = 1'b1;
                        if (nest_reg == '0)
                        begin
                            res.error = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            nest_next = nest_reg - LEVEL_BITS'(1);
                        end
                        res.level = lvl_new[7:0];
                    end
                    else
                    begin
                        res.byte_kind = KIND_SKIP;
                    end
                end
                else
                begin
                    res.byte_kind    = KIND_HEADER;
                    data_width_next  = data_byte[3:0];
                    ext_pending_next = data_byte[EXT_FLAG_BIT];
                    ext_count_next   = 8'd0;
                    remaining_next   = '0;
                    if (data_byte[3:0] > MAX_LEN_WIDTH)
                    begin
                        res.error = ERR_WIDE_LEN;
                    end
                    accum_next      = '0;
                    position_next   = 4'd0;
                    bytes_left_next = {1'b0, data_byte[6:4]} + 4'd1;
                    phase_next      = PH_IDLEN;
                end
            end
        endcase

        if (go_after_ext)
        begin
            ext_count_next = ext_count_reg + 8'd1;
        end
        if (go_after_id || go_after_ext)
        begin
            if (ext_pending_reg)
            begin
                phase_next = PH_EXTHDR;
            end
            else
            begin
                go_after_exts = 1'b1;
            end
        end
        if (go_after_exts)
        begin
            if (data_width_reg != 4'd0)
            begin
                accum_next      = '0;
                position_next   = 4'd0;
                bytes_left_next = data_width_reg;
                phase_next      = PH_DATALEN;
            end
            else
            begin
                go_complete = 1'b1;
            end
        end
        if (go_complete)
        begin
            res.element_start = 1'b1;
            nest_next         = nest_reg + LEVEL_BITS'(1);
            phase_next        = PH_HEADER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            remaining_reg   <= '0;
            accum_reg       <= '0;
            bytes_left_reg  <= '0;
            position_reg    <= '0;
            data_width_reg  <= '0;
            ext_pending_reg <= 1'b0;
            ext_count_reg   <= '0;
            ext_id_reg      <= '0;
            nest_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            remaining_reg   <= remaining_next;
            accum_reg       <= accum_next;
            bytes_left_reg  <= bytes_left_next;
            position_reg    <= position_next;
            data_width_reg  <= data_width_next;
            ext_pending_reg <= ext_pending_next;
            ext_count_reg   <= ext_count_next;
            ext_id_reg      <= ext_id_next;
            nest_reg        <= nest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ntlv_out_stage.sv
// ----------------------------------------------------------------------------
// ntlv_out_stage
// Result register between the parser step and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ntlv_out_stage
    import ntlv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    take,
    output logic         free,
    output logic         valid,
    output result_t      res_out
);

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign free    = !valid_reg || take;
    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/ntlv_checker.sv
// ----------------------------------------------------------------------------
// ntlv_checker
// Port-level checks of the parser unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nested_tlv_stream_parser_unit_defines.svh"

module ntlv_checker
    import ntlv_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] byte_kind,
    input wire logic [7:0] payload,
    input wire logic [7:0] level,
    input wire logic [7:0] ext_tag,
    input wire logic       element_end,
    input wire logic [1:0] error
);

    `NTLV_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(payload) && $stable(byte_kind) && $stable(level),
        "Stalled result changed.")
    `NTLV_ASSERT_IMPLY(a_ready_only_full, clk, rst_n, !in_ready,
        out_valid && !out_ready,
        "Input blocked while the result register could drain.")
    `NTLV_ASSERT_IMPLY(a_error_kind, clk, rst_n, out_valid && (error != ERR_NONE),
        (error == ERR_UNDERFLOW && byte_kind == KIND_END && level == 8'd0)
            || (error == ERR_WIDE_LEN && byte_kind == KIND_HEADER),
        "Error flagged on a wrong byte kind.")
    `NTLV_ASSERT_IMPLY(a_end_kind, clk, rst_n, out_valid && element_end,
        byte_kind == KIND_END,
        "Element end on a byte that is no end marker.")
    `NTLV_ASSERT_IMPLY(a_tag_kind, clk, rst_n, out_valid && (ext_tag != 8'd0),
        byte_kind == KIND_EXTHDR || byte_kind == KIND_EXTLEN || byte_kind == KIND_EXT,
        "Extension tag outside an extension.")

endmodule

bind nested_tlv_stream_parser_unit ntlv_checker u_ntlv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (stream.ready),
    .out_valid   (parsed.valid),
    .out_ready   (parsed.ready),
    .byte_kind   (parsed.byte_kind),
    .payload     (parsed.payload),
    .level       (parsed.level),
    .ext_tag     (parsed.ext_tag),
    .element_end (parsed.element_end),
    .error       (parsed.error)
);

`default_nettype wire
